// ===== rtl/shbi_pkg.sv =====
// shared constants and types for the string hash bucket index block
package shbi_pkg;

    localparam int HASH_W     = 64;
    localparam int HALF_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int BCOUNT_W   = 31;
    localparam int HASH_SHIFT = 15;
    localparam int DIV_STEPS  = HASH_W;
    localparam int STEP_CNT_W = $clog2(DIV_STEPS);

    localparam logic [HASH_W-1:0]   HASH_SEED    = 64'd5381;
    localparam logic [HALF_W-1:0]   HASH_MULT    = 32'h5bd1e995;
    localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 31'd1024;

    // front to queue write side
    typedef struct packed {
        logic              push;
        logic [HASH_W-1:0] hash;
    } shbi_push_t;

endpackage

// ===== rtl/shbi_front.sv =====
// front end: accepts key bytes and mixes them into the running hash
module shbi_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [shbi_pkg::BYTE_W-1:0]   s_key_byte,
    input  logic                          s_last_byte,
    input  logic                          s_empty_key,
    input  logic                          q_full,
    output shbi_pkg::shbi_push_t          q_wr
);
    import shbi_pkg::*;

    typedef enum logic {
        F_IDLE,
        F_MIX
    } front_state_t;

    front_state_t        state_reg, state_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [HASH_W-1:0]   prod_lo_reg, prod_lo_next;
    logic                last_reg, last_next;

    logic                accept;
    logic [HASH_W-1:0]   byte_sext;
    logic [HASH_W-1:0]   hash_xor;
    logic [HALF_W-1:0]   prod_hi;
    logic [HASH_W-1:0]   prod_sum;
    logic [HASH_W-1:0]   mixed;

    assign s_tready  = (state_reg == F_IDLE) && !q_full;
    assign accept    = s_tvalid && s_tready;
    assign byte_sext = {{(HASH_W-BYTE_W){s_key_byte[BYTE_W-1]}}, s_key_byte};
    assign hash_xor  = hash_reg ^ byte_sext;

    // upper half product only matters mod 2^64, so keep its low 32 bits
    assign prod_hi   = hash_reg[HASH_W-1:HALF_W] * HASH_MULT;
    assign prod_sum  = prod_lo_reg + {prod_hi, {HALF_W{1'b0}}};
    assign mixed     = prod_sum ^ (prod_sum >> HASH_SHIFT);

    always_comb begin
        state_next   = state_reg;
        hash_next    = hash_reg;
        prod_lo_next = prod_lo_reg;
        last_next    = last_reg;
        q_wr.push    = 1'b0;
        q_wr.hash    = hash_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (accept) begin
                    if (s_empty_key) begin
                        // empty key reduces the hash as it stands
                        q_wr.push = 1'b1;
                        hash_next = HASH_SEED;
                    end else begin
                        hash_next    = hash_xor;
                        prod_lo_next = HASH_W'(hash_xor[HALF_W-1:0]) * HASH_W'(HASH_MULT);
                        last_next    = s_last_byte;
                        state_next   = F_MIX;
                    end
                end
            end
            F_MIX: begin
                state_next = F_IDLE;
                if (last_reg) begin
                    q_wr.push = 1'b1;
                    q_wr.hash = mixed;
                    hash_next = HASH_SEED;
                end else begin
                    hash_next = mixed;
                end
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
            hash_reg  <= HASH_SEED;
            last_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            last_reg  <= last_next;
        end
        prod_lo_reg <= prod_lo_next;
    end

endmodule

// ===== rtl/shbi_queue.sv =====
// two-entry queue of finished hashes between front and back
module shbi_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  shbi_pkg::shbi_push_t          q_wr,
    output logic                          q_full,
    input  logic                          q_pop,
    output logic                          q_valid,
    output logic [shbi_pkg::HASH_W-1:0]   q_data
);
    import shbi_pkg::*;

    logic [HASH_W-1:0] mem [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;

    assign q_full  = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ q_wr.push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        count_next  = count_reg + 2'(q_wr.push) - 2'(q_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_wr.push) begin
            mem[wr_ptr_reg] <= q_wr.hash;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_full |-> !q_wr.push)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("queue count out of range");
    a_count_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_wr.push && !q_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a push");
`endif

endmodule

// ===== rtl/shbi_back.sv =====
// back end: reduces each hash modulo the bucket count, one quotient bit per cycle
module shbi_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [shbi_pkg::BCOUNT_W-1:0]   bucket_count,
    input  logic                            q_valid,
    input  logic [shbi_pkg::HASH_W-1:0]     q_data,
    output logic                            q_pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [shbi_pkg::BCOUNT_W-1:0]   m_bucket_index
);
    import shbi_pkg::*;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_HOLD
    } back_state_t;

    back_state_t           state_reg, state_next;
    logic [HASH_W-1:0]     dividend_reg, dividend_next;
    logic [BCOUNT_W-1:0]   rem_reg, rem_next;
    logic [STEP_CNT_W-1:0] step_reg, step_next;
    logic                  out_valid_reg, out_valid_next;
    logic [BCOUNT_W-1:0]   out_data_reg, out_data_next;

    logic [BCOUNT_W:0]     shifted;
    logic [BCOUNT_W:0]     diff;
    logic                  out_free;

    assign shifted  = {rem_reg, dividend_reg[HASH_W-1]};
    assign diff     = shifted - {1'b0, bucket_count};
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == B_IDLE) && q_valid;

    assign m_tvalid       = out_valid_reg;
    assign m_bucket_index = out_data_reg;

    always_comb begin
        state_next     = state_reg;
        dividend_next  = dividend_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    dividend_next = q_data;
                    rem_next      = '0;
                    step_next     = '0;
                    state_next    = B_DIV;
                end
            end
            B_DIV: begin
                // restoring step; remainder stays below a nonzero divisor
                if (shifted >= {1'b0, bucket_count}) begin
                    rem_next = diff[BCOUNT_W-1:0];
                end else begin
                    rem_next = shifted[BCOUNT_W-1:0];
                end
                dividend_next = dividend_reg << 1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = B_HOLD;
                end
            end
            B_HOLD: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = (bucket_count == '0) ? '0 : rem_reg;
                    state_next     = B_IDLE;
                end
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
        dividend_reg <= dividend_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_HOLD && bucket_count != '0) |-> (rem_reg < bucket_count))
        else $error("remainder not below bucket count");
    a_pop_starts_div: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |=> (state_reg == B_DIV && step_reg == '0))
        else $error("pop did not start a division");
    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_data_reg)))
        else $error("held result was overwritten");
`endif

endmodule

// ===== rtl/string_hash_bucket_index_top.sv =====
// String hash bucket index: streams key bytes in, returns one bucket index per key.
//
// Input channel (s_): one key byte per transfer in s_tdata, s_tlast marks the final
// byte of a key, s_tuser marks an empty key (byte ignored, current hash reduced).
// Output channel (m_): one bucket index per finished key, in key order.
// Configuration: cfg_we with cfg_wdata loads the bucket count (reset value 1024);
// write it only while no key is in flight. A count of zero yields index 0.
// The front end takes a new byte only after it has finished mixing the previous one
// in its two-step 64x32 multiply, and not while the queue is full. Each key then passes
// through the bit-serial remainder unit in the back end (64 steps plus load and hand-off);
// a two-entry queue lets the front keep mixing the next key meanwhile.
// From the last byte's transfer to m_tvalid a key passes the mix state, the queue, the
// load, the division steps and the hold state; an empty key skips the mix state.
// Reset (aresetn low, synchronous) reloads the hash seed 5381 and the default
// bucket count and drops any queued or pending result.
// When the receiver stalls the result holds in the output register, the back end
// waits and the queue fills, after which s_tready drops.
module string_hash_bucket_index_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [shbi_pkg::BCOUNT_W-1:0] cfg_wdata,   // bucket_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,     // key_byte
    input  logic                          s_tlast,     // last_byte
    input  logic                          s_tuser,     // empty_key
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [31:0]                   m_tdata      // bucket_index, bit 31 zero
);
    import shbi_pkg::*;

    logic [BCOUNT_W-1:0] bucket_count_reg, bucket_count_next;
    shbi_push_t          q_wr;
    logic                q_full;
    logic                q_pop;
    logic                q_valid;
    logic [HASH_W-1:0]   q_data;
    logic [BCOUNT_W-1:0] bucket_index;

    assign bucket_count_next = cfg_we ? cfg_wdata : bucket_count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= BCOUNT_RESET;
        end else begin
            bucket_count_reg <= bucket_count_next;
        end
    end

    shbi_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_key_byte  (s_tdata),
        .s_last_byte (s_tlast),
        .s_empty_key (s_tuser),
        .q_full      (q_full),
        .q_wr        (q_wr)
    );

    shbi_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_wr    (q_wr),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    shbi_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .bucket_count   (bucket_count_reg),
        .q_valid        (q_valid),
        .q_data         (q_data),
        .q_pop          (q_pop),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_bucket_index (bucket_index)
    );

    assign m_tdata = {1'b0, bucket_index};

endmodule

// ===== tb/tb.sv =====
// testbench for the string hash bucket index block: scoreboard class and top module
`timescale 1ns / 1ps

class hash_scoreboard;
    logic [63:0] running_hash;
    logic [30:0] bucket_count;
    logic [30:0] index_q[$];
    int          mismatches;

    function new();
        running_hash = shbi_pkg::HASH_SEED;
        bucket_count = shbi_pkg::BCOUNT_RESET;
        mismatches   = 0;
    endfunction

    function void set_count(logic [30:0] count);
        bucket_count = count;
    endfunction

    // mirror one accepted input transfer, queue an index when a key closes
    function void note_byte(logic [7:0] key_byte, logic last_byte, logic empty_key);
        logic [63:0] ext;
        logic [63:0] rem;
        if (!empty_key) begin
            ext = {{56{key_byte[7]}}, key_byte};
            running_hash = running_hash ^ ext;
            running_hash = running_hash * {32'd0, shbi_pkg::HASH_MULT};
            running_hash = running_hash ^ (running_hash >> shbi_pkg::HASH_SHIFT);
        end
        if (empty_key || last_byte) begin
            if (bucket_count == 31'd0)
                rem = 64'd0;
            else
                rem = running_hash % {33'd0, bucket_count};
            index_q.push_back(rem[30:0]);
            running_hash = shbi_pkg::HASH_SEED;
        end
    endfunction

    function void check_index(logic [31:0] got);
        logic [30:0] want;
        if (index_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("tb: index %h arrived with none pending", got);
        end else begin
            want = index_q.pop_front();
            if (got !== {1'b0, want}) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("tb: bucket_index expected %h got %h", {1'b0, want}, got);
            end
        end
    endfunction

    function int pending();
        return index_q.size();
    endfunction
endclass

module tb;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 120;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [30:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int send_idle_pct = 37;
    int recv_idle_pct = 62;
    int hold_left = 0;
    int cycle_count = 0;

    hash_scoreboard sb;

    string_hash_bucket_index_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_byte(s_tdata, s_tlast, s_tuser);
        if (aresetn && m_tvalid && m_tready)
            sb.check_index(m_tdata);
    end

    // result side: random stalls, or a long hold-off while hold_left runs down
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // entered and left at a rising edge; returns once s_tready is seen high after an edge
    task automatic send_byte(input logic [7:0] key_byte, input logic last_byte,
                             input logic empty_key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key_byte;
        s_tlast  <= last_byte;
        s_tuser  <= empty_key;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
    endtask

    task automatic wait_for_indexes();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_bucket_count(input logic [30:0] count);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        sb.set_count(count);
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed keys, now and then a lone empty key or a key cut short
    task automatic send_random_key(input int max_len, output int n_items);
        int len;
        int i;
        n_items = 0;
        if ($urandom_range(14) == 0) begin
            send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
            n_items = 1;
        end else begin
            len = $urandom_range(max_len, 1);
            for (i = 0; i < len; i++) begin
                if ($urandom_range(19) == 0) begin
                    send_byte(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
                    n_items++;
                end
                send_byte(8'($urandom_range(255)), i == len - 1, 1'b0);
                n_items++;
            end
        end
    endtask

    initial begin
        logic [30:0] counts[8];
        int phase;
        int sent;
        int n;

        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed keys at the reset bucket count
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'h7F, 1'b0, 1'b0);
        send_byte(8'h01, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'hAA, 1'b1, 1'b1);
        send_byte(8'h41, 1'b0, 1'b0);
        send_byte(8'h42, 1'b0, 1'b0);
        send_byte(8'h55, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'h00, 1'b1, 1'b0);
        send_byte(8'hFF, 1'b0, 1'b1);
        wait_for_indexes();

        // zero count gives index zero, then counts of one and of the largest value
        write_bucket_count(31'd0);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        wait_for_indexes();
        write_bucket_count(31'd1);
        send_byte(8'h33, 1'b0, 1'b0);
        send_byte(8'h44, 1'b1, 1'b0);
        wait_for_indexes();
        write_bucket_count(31'h7FFFFFFF);
        send_byte(8'hC3, 1'b0, 1'b0);
        send_byte(8'h3C, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b1);
        wait_for_indexes();

        counts[0] = 31'h7FFFFFFF;
        counts[1] = 31'd1;
        counts[2] = 31'd3;
        counts[3] = 31'd1000003;
        counts[4] = 31'($urandom_range(32'h7FFFFFFF, 1));
        counts[5] = 31'd0;
        counts[6] = 31'd65536;
        counts[7] = 31'($urandom_range(200, 1));

        for (phase = 0; phase < 8; phase++) begin
            if (phase < 3) begin
                send_idle_pct = 37;
                recv_idle_pct = 62;
            end else if (phase < 6) begin
                send_idle_pct = 62;
                recv_idle_pct = 37;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_bucket_count(counts[phase]);
            sent = 0;
            while (sent < 125) begin
                send_random_key(($urandom_range(9) == 0) ? 40 : 8, n);
                sent += n;
            end
            wait_for_indexes();
        end

        // long receiver hold-off with short keys fills the block
        write_bucket_count(31'd1024);
        hold_left = 600;
        sent = 0;
        while (sent < 60) begin
            send_random_key(2, n);
            sent += n;
        end
        wait_for_indexes();

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== string_hash_bucket_index_top.f =====
rtl/shbi_pkg.sv
rtl/shbi_front.sv
rtl/shbi_queue.sv
rtl/shbi_back.sv
rtl/string_hash_bucket_index_top.sv
tb/tb.sv
